// File: sv/crc16_packet_framer_core_assert.svh
// Assertion macros used by the framer checker.
`ifndef CRC16_PACKET_FRAMER_CORE_ASSERT_SVH
`define CRC16_PACKET_FRAMER_CORE_ASSERT_SVH

// Checked at every clock edge, also while reset is applied.
`define CRC16PF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// Checked only outside reset.
`define CRC16PF_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// File: sv/crc16pf_pkg.sv
`timescale 1ns / 1ps

package crc16pf_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [7:0]  SHORT_START = 8'd2;
   localparam logic [7:0]  LONG_START  = 8'd3;
   localparam logic [7:0]  END_BYTE    = 8'd3;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_DATA  = 1'b1;

   typedef enum logic [1:0] {
      OP_ERROR,
      OP_SHORT,
      OP_LONG,
      OP_DATA
   } op_type;

   // One decoded item: header, data or error part, optional trailer with its CRC.
   typedef struct packed {
      op_type      op;
      logic        trailer;
      logic [15:0] value;
      logic [15:0] crc;
   } cmd_type;

endpackage

// File: sv/crc16_packet_framer_core.sv
`timescale 1ns / 1ps

// CRC-16 packet framer for a serial link.
// Request channel (req_*): a start item (req_type 0) carries the payload length,
// a data item (req_type 1) carries one payload byte. Response channel (rsp_*)
// gives one framed byte per item: header 2,len or 3,len_hi,len_lo on a start;
// the payload byte on data; after the last byte CRC hi, CRC lo and end byte 3
// (rsp_frame_end). rsp_run_last marks the last byte caused by one request.
// A start while a packet is open, or data with none open, gives a single
// result with rsp_proto_error set and leaves the packet state alone.
// A request taken by the decoder is written into the queue; its first byte is
// then loaded into the output register once that register is free.
// Throughput: one request per cycle while each yields one byte and the receiver
// does not stall; the output stage emits one byte per cycle while rsp_ready is
// high, and longer header and trailer bursts are absorbed by a QUEUE_DEPTH-entry
// command queue between the decoder and the byte sequencer.
// When the receiver stalls, the output byte holds and the queue fills; req_ready
// drops only when the queue is full.
// Reset (synchronous, active high) closes any packet, empties the queue and
// drops rsp_valid.
module crc16_packet_framer_core #(
   parameter int QUEUE_DEPTH = crc16pf_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [15:0] req_packet_length,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end,
   output logic        rsp_run_last,
   output logic        rsp_proto_error
);
   import crc16pf_pkg::*;

   cmd_type push_cmd, head_cmd;
   logic    push_valid, q_full, q_empty, q_pop;

   crc16pf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_packet_length (req_packet_length),
      .req_data_byte     (req_data_byte),
      .cmd_valid         (push_valid),
      .cmd               (push_cmd),
      .cmd_full          (q_full)
   );

   crc16pf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (head_cmd)
   );

   crc16pf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_empty       (q_empty),
      .cmd             (head_cmd),
      .cmd_pop         (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_run_last    (rsp_run_last),
      .rsp_proto_error (rsp_proto_error)
   );

endmodule

// File: sv/crc16pf_front.sv
`timescale 1ns / 1ps

module crc16pf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [15:0]          req_packet_length,
   input  logic [7:0]           req_data_byte,
   output logic                 cmd_valid,
   output crc16pf_pkg::cmd_type cmd,
   input  logic                 cmd_full
);
   import crc16pf_pkg::*;

   logic        packet_open_ff, packet_open_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_next;
   logic [15:0] left_dec;
   logic        accept;

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   assign req_ready = !cmd_full;
   assign cmd_valid = req_valid;
   assign accept    = req_valid && req_ready;
   assign crc_next  = crc_fold(crc_ff, req_data_byte);
   assign left_dec  = bytes_left_ff - 16'd1;

   always_comb begin
      packet_open_in = packet_open_ff;
      bytes_left_in  = bytes_left_ff;
      crc_in         = crc_ff;
      cmd.op         = OP_ERROR;
      cmd.trailer    = 1'b0;
      cmd.value      = '0;
      cmd.crc        = '0;
      if (req_type == REQ_START) begin
         if (!packet_open_ff) begin
            cmd.op    = (req_packet_length[15:8] == 8'd0) ? OP_SHORT : OP_LONG;
            cmd.value = req_packet_length;
            crc_in    = '0;
            if (req_packet_length == 16'd0) begin
               cmd.trailer = 1'b1;
            end else begin
               bytes_left_in  = req_packet_length;
               packet_open_in = 1'b1;
            end
         end
      end else begin
         if (packet_open_ff) begin
            cmd.op        = OP_DATA;
            cmd.value     = {8'd0, req_data_byte};
            cmd.crc       = crc_next;
            crc_in        = crc_next;
            bytes_left_in = left_dec;
            if (left_dec == 16'd0) begin
               cmd.trailer    = 1'b1;
               packet_open_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_open_ff <= 1'b0;
         bytes_left_ff  <= '0;
         crc_ff         <= '0;
      end else if (accept) begin
         packet_open_ff <= packet_open_in;
         bytes_left_ff  <= bytes_left_in;
         crc_ff         <= crc_in;
      end
   end

endmodule

// File: sv/crc16pf_queue.sv
`timescale 1ns / 1ps

module crc16pf_queue #(
   parameter int DEPTH = crc16pf_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  crc16pf_pkg::cmd_type push_cmd,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output crc16pf_pkg::cmd_type head
);
   import crc16pf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ptr_inc(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= ptr_inc(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: sv/crc16pf_back.sv
`timescale 1ns / 1ps

module crc16pf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_empty,
   input  crc16pf_pkg::cmd_type cmd,
   output logic                 cmd_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_frame_end,
   output logic                 rsp_run_last,
   output logic                 rsp_proto_error
);
   import crc16pf_pkg::*;

   logic [2:0] step_ff;
   logic       rsp_valid_ff;
   logic [7:0] out_byte_ff;
   logic       frame_end_ff, run_last_ff, proto_error_ff;

   logic [2:0] hdr_n, total, tail_idx;
   logic [7:0] byte_in;
   logic       end_in, last_in, err_in;
   logic       load;

   assign load    = !cmd_empty && (!rsp_valid_ff || rsp_ready);
   assign cmd_pop = load && last_in;

   always_comb begin
      err_in = 1'b0;
      case (cmd.op)
         OP_SHORT: hdr_n = 3'd2;
         OP_LONG:  hdr_n = 3'd3;
         OP_ERROR: begin
            hdr_n  = 3'd1;
            err_in = 1'b1;
         end
         default:  hdr_n = 3'd1;
      endcase
      total    = hdr_n + (cmd.trailer ? 3'd3 : 3'd0);
      last_in  = (step_ff == total - 3'd1);
      tail_idx = step_ff - hdr_n;
      end_in   = 1'b0;
      byte_in  = 8'd0;
      if (step_ff < hdr_n) begin
         case (cmd.op)
            OP_SHORT: byte_in = (step_ff == 3'd0) ? SHORT_START : cmd.value[7:0];
            OP_LONG: begin
               case (step_ff)
                  3'd0:    byte_in = LONG_START;
                  3'd1:    byte_in = cmd.value[15:8];
                  default: byte_in = cmd.value[7:0];
               endcase
            end
            OP_DATA:  byte_in = cmd.value[7:0];
            default:  byte_in = 8'd0;
         endcase
      end else begin
         // trailer: CRC high, CRC low, end byte
         case (tail_idx)
            3'd0:    byte_in = cmd.crc[15:8];
            3'd1:    byte_in = cmd.crc[7:0];
            default: begin
               byte_in = END_BYTE;
               end_in  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            step_ff      <= last_in ? 3'd0 : step_ff + 3'd1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff    <= byte_in;
         frame_end_ff   <= end_in;
         run_last_ff    <= last_in;
         proto_error_ff <= err_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_frame_end   = frame_end_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_proto_error = proto_error_ff;

endmodule

// File: sv/crc16pf_checker.sv
`timescale 1ns / 1ps

`include "crc16_packet_framer_core_assert.svh"

module crc16pf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_frame_end,
   input logic        rsp_run_last,
   input logic        rsp_proto_error
);
   import crc16pf_pkg::*;

   `CRC16PF_ASSERT(a_idle_after_reset, $past(reset) |-> !rsp_valid, "rsp_valid after reset")

   `CRC16PF_ASSERT_RUN(a_rsp_hold,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last),
      "stalled item changed")

   `CRC16PF_ASSERT_RUN(a_end_byte,
      rsp_valid && rsp_frame_end |-> rsp_run_last && !rsp_proto_error && rsp_out_byte == END_BYTE,
      "bad closing byte")

   `CRC16PF_ASSERT_RUN(a_error_item,
      rsp_valid && rsp_proto_error |-> rsp_run_last && !rsp_frame_end && rsp_out_byte == 8'd0,
      "bad error item")

endmodule

bind crc16_packet_framer_core crc16pf_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_frame_end   (rsp_frame_end),
   .rsp_run_last    (rsp_run_last),
   .rsp_proto_error (rsp_proto_error)
);
